// ----- rtl/tlc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, codes and helpers for the traffic light controller.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int COUNT_WIDTH_DEF = 8;

  localparam int COORD_W = 12;
  localparam int TICK_W  = 8;
  localparam int LAMP_W  = 2;
  localparam int MODE_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_X_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_X_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_X_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_X_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_Y_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_Y_HIGH = 3'd7;

  // Register reset values
  localparam logic [TICK_W-1:0]  HOLD_TICKS_RST    = 8'd2;
  localparam logic [TICK_W-1:0]  LIGHT_TICKS_RST   = 8'd5;
  localparam logic [COORD_W-1:0] POWER_X_LOW_RST   = 12'd650;
  localparam logic [COORD_W-1:0] POWER_X_HIGH_RST  = 12'd960;
  localparam logic [COORD_W-1:0] WALK_X_LOW_RST    = 12'd1500;
  localparam logic [COORD_W-1:0] WALK_X_HIGH_RST   = 12'd1750;
  localparam logic [COORD_W-1:0] BUTTON_Y_LOW_RST  = 12'd600;
  localparam logic [COORD_W-1:0] BUTTON_Y_HIGH_RST = 12'd850;

  // Lamp codes
  localparam logic [LAMP_W-1:0] LAMP_OFF    = 2'd0;
  localparam logic [LAMP_W-1:0] LAMP_RED    = 2'd1;
  localparam logic [LAMP_W-1:0] LAMP_YELLOW = 2'd2;
  localparam logic [LAMP_W-1:0] LAMP_GREEN  = 2'd3;

  // Mode codes as seen on the result channel
  localparam logic [MODE_W-1:0] MODE_OFF       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_ON_HOLD   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_STOP      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_STOP_HOLD = 4'd3;
  localparam logic [MODE_W-1:0] MODE_GO        = 4'd4;
  localparam logic [MODE_W-1:0] MODE_GO_HOLD   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_WALK_HOLD = 4'd6;
  localparam logic [MODE_W-1:0] MODE_WARN      = 4'd7;
  localparam logic [MODE_W-1:0] MODE_WARN_HOLD = 4'd8;

  typedef enum logic [8:0] {
    ST_OFF       = 9'b000000001,
    ST_ON_HOLD   = 9'b000000010,
    ST_STOP      = 9'b000000100,
    ST_STOP_HOLD = 9'b000001000,
    ST_GO        = 9'b000010000,
    ST_GO_HOLD   = 9'b000100000,
    ST_WALK_HOLD = 9'b001000000,
    ST_WARN      = 9'b010000000,
    ST_WARN_HOLD = 9'b100000000
  } state_t;

  function automatic logic [MODE_W-1:0] mode_code(input state_t st);
    logic [MODE_W-1:0] m;
    unique case (st)
      ST_ON_HOLD:   m = MODE_ON_HOLD;
      ST_STOP:      m = MODE_STOP;
      ST_STOP_HOLD: m = MODE_STOP_HOLD;
      ST_GO:        m = MODE_GO;
      ST_GO_HOLD:   m = MODE_GO_HOLD;
      ST_WALK_HOLD: m = MODE_WALK_HOLD;
      ST_WARN:      m = MODE_WARN;
      ST_WARN_HOLD: m = MODE_WARN_HOLD;
      default:      m = MODE_OFF;
    endcase
    return m;
  endfunction

  // Hold states keep the lamp of the state they were entered from
  function automatic logic [LAMP_W-1:0] lamp_of(input logic [MODE_W-1:0] m);
    logic [LAMP_W-1:0] l;
    case (m) inside
      MODE_STOP, MODE_STOP_HOLD:               l = LAMP_RED;
      MODE_GO, MODE_GO_HOLD, MODE_WALK_HOLD:   l = LAMP_GREEN;
      MODE_WARN, MODE_WARN_HOLD:               l = LAMP_YELLOW;
      default:                                 l = LAMP_OFF;
    endcase
    return l;
  endfunction

endpackage

// ----- rtl/tlc_sample_if.sv -----
// ----------------------------------------------------------------------------
// tlc_sample_if
// Touch sample channel: one request per tick.
// ----------------------------------------------------------------------------
interface tlc_sample_if
  import tlc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] touch_x;
  logic [COORD_W-1:0] touch_y;

  modport source (output valid, output touch_x, output touch_y, input ready);
  modport sink   (input valid, input touch_x, input touch_y, output ready);
endinterface

// ----- rtl/tlc_result_if.sv -----
// ----------------------------------------------------------------------------
// tlc_result_if
// Result channel: lamp and mode after each tick.
// ----------------------------------------------------------------------------
interface tlc_result_if
  import tlc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [LAMP_W-1:0] lamp;
  logic [MODE_W-1:0] mode;

  modport source (output valid, output lamp, output mode, input ready);
  modport sink   (input valid, input lamp, input mode, output ready);
endinterface

// ----- rtl/tlc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// tlc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tlc_cfg_if
  import tlc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/traffic_light_controller.sv -----
// ----------------------------------------------------------------------------
// traffic_light_controller
// Nine-state traffic light machine stepped by one touch sample per tick.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one request per tick carrying touch_x / touch_y. The point is
//            tested against the power and walk button windows (exclusive
//            bounds, shared y bounds) and steps the light machine.
//   result : one request per sample: lamp to show and mode after the tick.
//   cfg    : register writes (hold_ticks, light_ticks, window bounds), always
//            ready; write only while no sample is in flight.
// Path: an accepted sample is held in the sample register, and its result
//   in the result register. Throughput: one sample per cycle while results
//   are taken. The whole state step is one compare-and-select pass between
//   the sample and result registers, so a sample follows with no gap.
// Stall: while the result waits on ready, one more sample is still taken into
//   the sample register; after that sample.ready drops until the result
//   drains. Nothing is dropped or repeated.
// Reset: rst (synchronous) returns the machine to off, clears all counters,
//   loads the register defaults and empties both pipeline registers.
// ----------------------------------------------------------------------------
module traffic_light_controller
  import tlc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tlc_cfg_if.sink      cfg,
  tlc_sample_if.sink   sample,
  tlc_result_if.source result
);

  // Compare width wide enough for both the counters and the 8-bit tick regs
  localparam int CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // ---- configuration registers ----
  logic [TICK_W-1:0]  hold_ticks;
  logic [TICK_W-1:0]  light_ticks;
  logic [COORD_W-1:0] power_x_low;
  logic [COORD_W-1:0] power_x_high;
  logic [COORD_W-1:0] walk_x_low;
  logic [COORD_W-1:0] walk_x_high;
  logic [COORD_W-1:0] button_y_low;
  logic [COORD_W-1:0] button_y_high;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks    <= HOLD_TICKS_RST;
      light_ticks   <= LIGHT_TICKS_RST;
      power_x_low   <= POWER_X_LOW_RST;
      power_x_high  <= POWER_X_HIGH_RST;
      walk_x_low    <= WALK_X_LOW_RST;
      walk_x_high   <= WALK_X_HIGH_RST;
      button_y_low  <= BUTTON_Y_LOW_RST;
      button_y_high <= BUTTON_Y_HIGH_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HOLD_TICKS:    hold_ticks    <= cfg.data[TICK_W-1:0];
        REG_LIGHT_TICKS:   light_ticks   <= cfg.data[TICK_W-1:0];
        REG_POWER_X_LOW:   power_x_low   <= cfg.data;
        REG_POWER_X_HIGH:  power_x_high  <= cfg.data;
        REG_WALK_X_LOW:    walk_x_low    <= cfg.data;
        REG_WALK_X_HIGH:   walk_x_high   <= cfg.data;
        REG_BUTTON_Y_LOW:  button_y_low  <= cfg.data;
        REG_BUTTON_Y_HIGH: button_y_high <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---- sample register ----
  logic               s1_valid;
  logic [COORD_W-1:0] s1_x;
  logic [COORD_W-1:0] s1_y;
  logic               advance;   // sample register moves into result register

  assign advance      = s1_valid && (!result.valid || result.ready);
  assign sample.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_x <= sample.touch_x;
      s1_y <= sample.touch_y;
    end
  end

  // ---- button decode: all bounds exclusive, y shared ----
  logic y_hit, pwr, walk;
  assign y_hit = (s1_y > button_y_low) && (s1_y < button_y_high);
  assign pwr   = y_hit && (s1_x > power_x_low) && (s1_x < power_x_high);
  assign walk  = y_hit && (s1_x > walk_x_low) && (s1_x < walk_x_high);

  // ---- machine state ----
  state_t                 state, state_next;
  logic [COUNT_WIDTH-1:0] phase_count, phase_count_next;
  logic [COUNT_WIDTH-1:0] power_hold_count, power_hold_count_next;
  logic [COUNT_WIDTH-1:0] walk_hold_count, walk_hold_count_next;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + COUNT_WIDTH'(1);
  endfunction

  logic phold_short, whold_short, phase_short;
  assign phold_short = CMP_W'(power_hold_count) < CMP_W'(hold_ticks);
  assign whold_short = CMP_W'(walk_hold_count)  < CMP_W'(hold_ticks);
  assign phase_short = CMP_W'(phase_count)      < CMP_W'(light_ticks);

  // Power-off hold return target, shared by the three lit hold states
  state_t back_to;
  always_comb begin
    unique case (state)
      ST_STOP_HOLD: back_to = ST_STOP;
      ST_GO_HOLD:   back_to = ST_GO;
      default:      back_to = ST_WARN;
    endcase
  end

  always_comb begin
    state_next            = state;
    phase_count_next      = phase_count;
    power_hold_count_next = power_hold_count;
    walk_hold_count_next  = walk_hold_count;
    unique case (state)
      ST_ON_HOLD: begin
        if (pwr && phold_short) begin
          power_hold_count_next = sat_inc(power_hold_count);
        end else if (pwr) begin
          state_next            = ST_STOP;
          phase_count_next      = '0;
          power_hold_count_next = '0;
          walk_hold_count_next  = '0;
        end else begin
          state_next            = ST_OFF;
          power_hold_count_next = '0;
        end
      end
      ST_STOP, ST_GO, ST_WARN: begin
        if (pwr) begin
          // lit state: power press starts the power-off hold
          unique case (state)
            ST_STOP: state_next = ST_STOP_HOLD;
            ST_GO:   state_next = ST_GO_HOLD;
            default: state_next = ST_WARN_HOLD;
          endcase
          power_hold_count_next = '0;
        end else if (state == ST_GO && walk) begin
          state_next           = ST_WALK_HOLD;
          walk_hold_count_next = '0;
        end else if (phase_short) begin
          phase_count_next = sat_inc(phase_count);
        end else begin
          state_next       = (state == ST_STOP) ? ST_GO : ST_STOP;
          phase_count_next = '0;
        end
      end
      ST_STOP_HOLD, ST_GO_HOLD, ST_WARN_HOLD: begin
        if (pwr && phold_short) begin
          power_hold_count_next = sat_inc(power_hold_count);
          phase_count_next      = sat_inc(phase_count);
        end else if (pwr) begin
          state_next            = ST_OFF;
          power_hold_count_next = '0;
          phase_count_next      = '0;
          walk_hold_count_next  = '0;
        end else begin
          state_next            = back_to;
          phase_count_next      = sat_inc(phase_count);
          power_hold_count_next = '0;
        end
      end
      ST_WALK_HOLD: begin
        if (walk && whold_short) begin
          walk_hold_count_next = sat_inc(walk_hold_count);
          phase_count_next     = sat_inc(phase_count);
        end else if (walk) begin
          state_next            = ST_WARN;
          walk_hold_count_next  = '0;
          phase_count_next      = '0;
          power_hold_count_next = '0;
        end else begin
          state_next           = ST_GO;
          phase_count_next     = sat_inc(phase_count);
          walk_hold_count_next = '0;
        end
      end
      default: begin
        // off, and any corrupt code
        state_next            = pwr ? ST_ON_HOLD : ST_OFF;
        power_hold_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_OFF;
      phase_count      <= '0;
      power_hold_count <= '0;
      walk_hold_count  <= '0;
    end else if (advance) begin
      state            <= state_next;
      phase_count      <= phase_count_next;
      power_hold_count <= power_hold_count_next;
      walk_hold_count  <= walk_hold_count_next;
    end
  end

  // ---- result register ----
  logic              out_valid;
  logic [LAMP_W-1:0] out_lamp;
  logic [MODE_W-1:0] out_mode;
  logic [MODE_W-1:0] mode_next;

  assign mode_next = mode_code(state_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode <= mode_next;
      out_lamp <= lamp_of(mode_next);
    end
  end

  assign result.valid = out_valid;
  assign result.lamp  = out_lamp;
  assign result.mode  = out_mode;

endmodule

// ----- rtl/tlc_checker.sv -----
// ----------------------------------------------------------------------------
// tlc_checker
// Port-level checks on the traffic light controller, bound to the top level.
// ----------------------------------------------------------------------------
module tlc_checker
  import tlc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [LAMP_W-1:0] res_lamp,
  input logic [MODE_W-1:0] res_mode
);

  // Result register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A stalled result holds its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_lamp) && $stable(res_mode))
    else $error("stalled result changed");

  // Only the nine defined modes are ever reported
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_mode <= MODE_WARN_HOLD)
    else $error("mode code out of range");

  // Lamp always matches the reported mode
  a_lamp_mode: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_lamp == lamp_of(res_mode))
    else $error("lamp does not match mode");

endmodule

bind traffic_light_controller tlc_checker u_tlc_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_lamp  (result.lamp),
  .res_mode  (result.mode)
);

// ----- verif/traffic_light_controller_test.sv -----
// ----------------------------------------------------------------------------
// traffic_light_controller_test
// Self-checking bench for the touch-driven traffic light machine. A short
// hand-written walk through power-on, both hold kinds and every light phase
// is followed by randomized button presses under several register settings.
// Each result is checked against an in-bench model of the state machine.
// ----------------------------------------------------------------------------
module traffic_light_controller_test
  import tlc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW          = COUNT_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [LAMP_W-1:0] lamp;
    logic [MODE_W-1:0] mode;
  } lights_t;

  // Where a generated touch lands
  typedef enum int {AIM_POWER, AIM_WALK, AIM_MISS, AIM_NOISE} aim_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the light machine and the queue of expected results.
  // --------------------------------------------------------------------------
  class light_scoreboard;
    logic [TICK_W-1:0]  hold_ticks, light_ticks;
    logic [COORD_W-1:0] pwr_xl, pwr_xh, walk_xl, walk_xh, btn_yl, btn_yh;
    logic [MODE_W-1:0]  mode;
    logic [CW-1:0]      phase_cnt, pwr_hold, walk_hold;
    lights_t            expected_lights[$];
    int                 errors;

    function new();
      hold_ticks  = HOLD_TICKS_RST;
      light_ticks = LIGHT_TICKS_RST;
      pwr_xl      = POWER_X_LOW_RST;
      pwr_xh      = POWER_X_HIGH_RST;
      walk_xl     = WALK_X_LOW_RST;
      walk_xh     = WALK_X_HIGH_RST;
      btn_yl      = BUTTON_Y_LOW_RST;
      btn_yh      = BUTTON_Y_HIGH_RST;
      mode        = MODE_OFF;
      phase_cnt   = '0;
      pwr_hold    = '0;
      walk_hold   = '0;
      errors      = 0;
    endfunction

    function void report(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HOLD_TICKS:    hold_ticks  = data[TICK_W-1:0];
        REG_LIGHT_TICKS:   light_ticks = data[TICK_W-1:0];
        REG_POWER_X_LOW:   pwr_xl      = data;
        REG_POWER_X_HIGH:  pwr_xh      = data;
        REG_WALK_X_LOW:    walk_xl     = data;
        REG_WALK_X_HIGH:   walk_xh     = data;
        REG_BUTTON_Y_LOW:  btn_yl      = data;
        REG_BUTTON_Y_HIGH: btn_yh      = data;
        default: ;
      endcase
    endfunction

    function logic [CW-1:0] bump(logic [CW-1:0] v);
      return (v == '1) ? v : v + CW'(1);
    endfunction

    function logic hit(logic [COORD_W-1:0] x, y, xl, xh);
      return x > xl && x < xh && y > btn_yl && y < btn_yh;
    endfunction

    function logic [LAMP_W-1:0] lamp_for(logic [MODE_W-1:0] m);
      case (m)
        MODE_STOP, MODE_STOP_HOLD:             return LAMP_RED;
        MODE_GO, MODE_GO_HOLD, MODE_WALK_HOLD: return LAMP_GREEN;
        MODE_WARN, MODE_WARN_HOLD:             return LAMP_YELLOW;
        default:                               return LAMP_OFF;
      endcase
    endfunction

    // power-off hold from a lit state; drop back to lit_mode on release
    function void power_off_hold(logic pwr, logic [MODE_W-1:0] lit_mode);
      if (pwr && pwr_hold < hold_ticks) begin
        pwr_hold  = bump(pwr_hold);
        phase_cnt = bump(phase_cnt);
      end else if (pwr) begin
        pwr_hold  = '0;
        phase_cnt = '0;
        walk_hold = '0;
        mode      = MODE_OFF;
      end else begin
        mode      = lit_mode;
        phase_cnt = bump(phase_cnt);
        pwr_hold  = '0;
      end
    endfunction

    function void light_phase(logic [MODE_W-1:0] next_mode);
      if (phase_cnt < light_ticks) begin
        phase_cnt = bump(phase_cnt);
      end else begin
        mode      = next_mode;
        phase_cnt = '0;
      end
    endfunction

    // One tick of the machine; queues the lamp/mode it should produce
    function void note_touch(logic [COORD_W-1:0] x, y);
      logic    pwr, walk;
      lights_t exp_l;
      pwr  = hit(x, y, pwr_xl, pwr_xh);
      walk = hit(x, y, walk_xl, walk_xh);
      case (mode)
        MODE_ON_HOLD: begin
          if (pwr && pwr_hold < hold_ticks) begin
            pwr_hold = bump(pwr_hold);
          end else if (pwr) begin
            mode      = MODE_STOP;
            phase_cnt = '0;
            pwr_hold  = '0;
            walk_hold = '0;
          end else begin
            mode     = MODE_OFF;
            pwr_hold = '0;
          end
        end
        MODE_STOP: begin
          if (pwr) begin
            mode     = MODE_STOP_HOLD;
            pwr_hold = '0;
          end else begin
            light_phase(MODE_GO);
          end
        end
        MODE_STOP_HOLD: power_off_hold(pwr, MODE_STOP);
        MODE_GO: begin
          // power wins over walk when the windows overlap
          if (pwr) begin
            mode     = MODE_GO_HOLD;
            pwr_hold = '0;
          end else if (walk) begin
            mode      = MODE_WALK_HOLD;
            walk_hold = '0;
          end else begin
            light_phase(MODE_STOP);
          end
        end
        MODE_GO_HOLD: power_off_hold(pwr, MODE_GO);
        MODE_WALK_HOLD: begin
          if (walk && walk_hold < hold_ticks) begin
            walk_hold = bump(walk_hold);
            phase_cnt = bump(phase_cnt);
          end else if (walk) begin
            walk_hold = '0;
            phase_cnt = '0;
            pwr_hold  = '0;
            mode      = MODE_WARN;
          end else begin
            mode      = MODE_GO;
            phase_cnt = bump(phase_cnt);
            walk_hold = '0;
          end
        end
        MODE_WARN: begin
          if (pwr) begin
            mode     = MODE_WARN_HOLD;
            pwr_hold = '0;
          end else begin
            light_phase(MODE_STOP);
          end
        end
        MODE_WARN_HOLD: power_off_hold(pwr, MODE_WARN);
        default: begin
          mode     = pwr ? MODE_ON_HOLD : MODE_OFF;
          pwr_hold = '0;
        end
      endcase
      exp_l.lamp = lamp_for(mode);
      exp_l.mode = mode;
      expected_lights.push_back(exp_l);
    endfunction

    function void check_lights(logic [LAMP_W-1:0] lamp, logic [MODE_W-1:0] mode_seen);
      lights_t exp_l;
      if (expected_lights.size() == 0) begin
        report($sformatf("result lamp=%0d mode=%0d with no request pending", lamp, mode_seen));
        return;
      end
      exp_l = expected_lights.pop_front();
      if (lamp !== exp_l.lamp)
        report($sformatf("lamp %0d, expected %0d", lamp, exp_l.lamp));
      if (mode_seen !== exp_l.mode)
        report($sformatf("mode %0d, expected %0d", mode_seen, exp_l.mode));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tlc_cfg_if    cfg_ch();
  tlc_sample_if touch_ch();
  tlc_result_if lights_ch();

  traffic_light_controller i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (touch_ch),
    .result (lights_ch)
  );

  light_scoreboard sb = new();

  bit idle_on = 1'b1;  // random idling on both sides; cleared for the last phase
  int stall_left = 0;
  int cycles = 0;

  // Directed walk under the reset register values (windows: power x 650..960,
  // walk x 1500..1750, y 600..850, hold 2, light 5):
  //   corners and an on-the-bound touch in off, power held until stop, a walk
  //   touch in stop (ignored), a released power-off hold, light phase to go,
  //   walk held until warn, then power held from warn until off.
  localparam int DIR_N = 22;
  int unsigned dir_x [DIR_N] = '{0, 4095, 650, 651, 959, 800, 800, 1600, 800, 0,
                                 4095, 2000, 1500, 1750, 1501, 1749, 1600, 1600,
                                 800, 800, 800, 800};
  int unsigned dir_y [DIR_N] = '{0, 4095, 700, 601, 849, 700, 700, 700, 700, 4095,
                                 0, 2000, 700, 700, 601, 849, 700, 700,
                                 700, 700, 700, 700};

  // --------------------------------------------------------------------------
  // Monitor: every handshake is sampled at the clock edge, before the
  // DUT's and the drivers' updates for that edge land. Touch requests are
  // noted before results are checked so a combinational path would also work.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (touch_ch.valid && touch_ch.ready)
        sb.note_touch(touch_ch.touch_x, touch_ch.touch_y);
      if (lights_ch.valid && lights_ch.ready)
        sb.check_lights(lights_ch.lamp, lights_ch.mode);
    end
  end

  // Result-side back-pressure: ready is held low in random bursts while idling is on
  always @(posedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      lights_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      lights_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      lights_ch.ready <= 1'b0;
    end else begin
      lights_ch.ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Point strictly between two exclusive bounds, often just inside one of them;
  // an empty window gives a random coordinate.
  function automatic logic [COORD_W-1:0] pick_between(logic [COORD_W-1:0] lo, hi);
    int unsigned r;
    if (hi <= lo + 1)
      return COORD_W'($urandom_range(0, 4095));
    r = $urandom_range(0, 3);
    if (r == 0) return lo + COORD_W'(1);
    if (r == 1) return hi - COORD_W'(1);
    return COORD_W'($urandom_range(lo + 1, hi - 1));
  endfunction

  task automatic aim(input aim_t kind, output logic [COORD_W-1:0] x, y);
    case (kind)
      AIM_POWER: begin
        x = pick_between(sb.pwr_xl, sb.pwr_xh);
        y = pick_between(sb.btn_yl, sb.btn_yh);
      end
      AIM_WALK: begin
        x = pick_between(sb.walk_xl, sb.walk_xh);
        y = pick_between(sb.btn_yl, sb.btn_yh);
      end
      AIM_MISS: begin
        x = COORD_W'($urandom_range(0, 4095));
        y = COORD_W'($urandom_range(0, 4095));
        // landing on the low y bound is outside both windows
        if (sb.hit(x, y, sb.pwr_xl, sb.pwr_xh) || sb.hit(x, y, sb.walk_xl, sb.walk_xh))
          y = sb.btn_yl;
      end
      default: begin
        x = COORD_W'($urandom_range(0, 4095));
        y = COORD_W'($urandom_range(0, 4095));
      end
    endcase
  endtask

  // One touch request; returns right after the edge that accepted it.
  // valid stays high so back-to-back requests need no extra assignment.
  task automatic send_touch(input logic [COORD_W-1:0] x, y);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      touch_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    touch_ch.valid   <= 1'b1;
    touch_ch.touch_x <= x;
    touch_ch.touch_y <= y;
    @(posedge clk);
    while (!touch_ch.ready) @(posedge clk);
  endtask

  // Stop sending, wait for every outstanding result and let the sample and
  // result registers go quiet. The first edge lets the monitor note the last
  // accepted request before the queue is looked at.
  task automatic drain_results();
    touch_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_lights.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Random traffic: mostly button holds sized around hold_ticks (so holds
  // both complete and get released early) and idle runs sized around
  // light_ticks (so phases advance), with some fully random touches.
  task automatic random_touches(input int n_items);
    int          sent;
    int          run_len;
    int unsigned r;
    aim_t        kind;
    logic [COORD_W-1:0] x, y;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        kind    = AIM_NOISE;
        run_len = 1;
      end else if (r < 75) begin
        kind = (r < 50) ? AIM_POWER : AIM_WALK;
        case ($urandom_range(0, 5))
          0:       run_len = sb.hold_ticks + 1;
          1:       run_len = sb.hold_ticks + 2;
          2:       run_len = sb.hold_ticks + 3;
          default: run_len = $urandom_range(1, sb.hold_ticks + 3);
        endcase
      end else begin
        kind    = AIM_MISS;
        run_len = $urandom_range(1, sb.light_ticks + 2);
      end
      for (int i = 0; i < run_len && sent < n_items; i++) begin
        aim(kind, x, y);
        send_touch(x, y);
        sent++;
      end
    end
  endtask

  // Reprogram every register while idle, then run random traffic
  task automatic run_phase(input logic [TICK_W-1:0] hold, light,
                           input logic [COORD_W-1:0] pxl, pxh, wxl, wxh, yl, yh,
                           input int n_items, input bit idle);
    drain_results();
    cfg_write(REG_HOLD_TICKS,    CFG_DATA_W'(hold));
    cfg_write(REG_LIGHT_TICKS,   CFG_DATA_W'(light));
    cfg_write(REG_POWER_X_LOW,   pxl);
    cfg_write(REG_POWER_X_HIGH,  pxh);
    cfg_write(REG_WALK_X_LOW,    wxl);
    cfg_write(REG_WALK_X_HIGH,   wxh);
    cfg_write(REG_BUTTON_Y_LOW,  yl);
    cfg_write(REG_BUTTON_Y_HIGH, yh);
    cfg_ch.valid <= 1'b0;
    idle_on = idle;
    random_touches(n_items);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    touch_ch.valid   = 1'b0;
    touch_ch.touch_x = '0;
    touch_ch.touch_y = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    lights_ch.ready  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk, then random traffic, on the reset register values
    for (int i = 0; i < DIR_N; i++)
      send_touch(COORD_W'(dir_x[i]), COORD_W'(dir_y[i]));
    random_touches(100);

    // Zero-length holds and phases: every power touch completes at once
    run_phase(8'd0, 8'd0, 12'd650, 12'd960, 12'd1500, 12'd1750, 12'd600, 12'd850, 150, 1'b1);

    // Overlapping windows: power must win over walk while in go
    run_phase(8'd1, 8'd3, 12'd100, 12'd2000, 12'd1000, 12'd3000, 12'd300, 12'd3500,
              200, 1'b1);

    // Longest hold and phase, windows touching the coordinate extremes;
    // long holds also drive the phase counter into saturation
    run_phase(8'd255, 8'd255, 12'd0, 12'd2048, 12'd2047, 12'd4095, 12'd0, 12'd4095,
              450, 1'b1);

    // Walk window with equal bounds never matches
    run_phase(8'd3, 8'd7, 12'd200, 12'd900, 12'd3000, 12'd3000, 12'd100, 12'd4000,
              150, 1'b1);

    // Last stretch at full rate, no idling on either side
    run_phase(8'd4, 8'd2, 12'd650, 12'd960, 12'd1500, 12'd1750, 12'd600, 12'd850,
              200, 1'b0);

    drain_results();
    repeat (4) @(posedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
